// ----- rtl/core/oanc_pkg.sv -----
// shared types, constants and helpers for the navigation controller
`timescale 1ns / 1ps

package oanc_pkg;

	// field widths
	localparam int DIST_W    = 12;
	localparam int IMU_W     = 16;
	localparam int TIME_W    = 32;
	localparam int ACT_W     = 3;
	localparam int SPEED_W   = 8;
	localparam int NAV_W     = 2;
	localparam int TILT_W    = 15;
	localparam int ROT_W     = 14;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;

	// default fixed point fraction bits
	localparam int FRAC_BITS_DEF = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TILT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MINDIST = 2'd2;

	// configuration reset values
	localparam logic [TILT_W-1:0] TILT_RST    = 15'd8000;
	localparam logic [ROT_W-1:0]  ROT_RST     = 14'd50;
	localparam logic [DIST_W-1:0] MINDIST_RST = 12'd20;

	// smoothing coefficients, denominator 2^COEF_SHIFT
	localparam logic signed [8:0] GYRO_KEEP = 9'sd230;
	localparam logic signed [8:0] GYRO_TAKE = 9'sd26;
	localparam logic signed [8:0] ACC_KEEP  = 9'sd205;
	localparam logic signed [8:0] ACC_TAKE  = 9'sd51;
	localparam int                COEF_SHIFT = 8;

	// timing windows in ms
	localparam logic [TIME_W-1:0] STOP_MS = 32'd500;
	localparam logic [TIME_W-1:0] TURN_MS = 32'd1500;
	localparam logic [TIME_W-1:0] CORR_MS = 32'd100;

	// gyro deadzone in raw units
	localparam int DEADZONE = 20;

	// servo targets and ramp steps
	localparam logic [SPEED_W-1:0] SERVO_RST  = 8'd90;
	localparam logic [SPEED_W-1:0] FWD_L      = 8'd180;
	localparam logic [SPEED_W-1:0] FWD_R      = 8'd0;
	localparam logic [SPEED_W-1:0] CORR_POS_L = 8'd170;
	localparam logic [SPEED_W-1:0] CORR_POS_R = 8'd0;
	localparam logic [SPEED_W-1:0] CORR_NEG_L = 8'd180;
	localparam logic [SPEED_W-1:0] CORR_NEG_R = 8'd10;
	localparam logic [SPEED_W-1:0] STEP_FAST  = 8'd5;
	localparam logic [SPEED_W-1:0] STEP_SLOW  = 8'd2;

	// motor command codes
	typedef enum logic [ACT_W-1:0] {
		ACT_NONE  = 3'd0,
		ACT_SERVO = 3'd1,
		ACT_STOP  = 3'd2,
		ACT_RIGHT = 3'd3,
		ACT_LEFT  = 3'd4,
		ACT_TILT  = 3'd5
	} action_t;

	// navigation mode, one-hot
	typedef enum logic [2:0] {
		MODE_FWD   = 3'b001,
		MODE_AVOID = 3'b010,
		MODE_ADJ   = 3'b100
	} mode_t;

	// reported mode codes
	localparam logic [NAV_W-1:0] NAV_FWD   = 2'd0;
	localparam logic [NAV_W-1:0] NAV_AVOID = 2'd1;
	localparam logic [NAV_W-1:0] NAV_ADJ   = 2'd2;

	// filter status handed to the mode logic
	typedef struct packed {
		logic tilt;
		logic rot_big;
		logic dead_big;
		logic gyro_pos;
	} imu_flags_t;

	// one result beat
	typedef struct packed {
		action_t              action;
		logic [SPEED_W-1:0]   left_speed;
		logic [SPEED_W-1:0]   right_speed;
		logic [NAV_W-1:0]     nav_mode;
	} nav_res_t;

	// move cur toward tgt by step without overshoot
	function automatic logic [SPEED_W-1:0] ramp(input logic [SPEED_W-1:0] cur,
			input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] step);
		logic [SPEED_W:0]   up;
		logic [SPEED_W-1:0] dn;
		up = {1'b0, cur} + {1'b0, step};
		dn = cur - step;
		if (cur < tgt) begin
			ramp = (up > {1'b0, tgt}) ? tgt : up[SPEED_W-1:0];
		end else if (cur > tgt) begin
			ramp = ((cur - tgt) <= step) ? tgt : dn;
		end else begin
			ramp = cur;
		end
	endfunction

endpackage

// ----- rtl/core/oanc_sample_if.sv -----
// sample channel: valid, ready and the sensor payload
`timescale 1ns / 1ps

interface oanc_sample_if
	import oanc_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [DIST_W-1:0]        distance;
	logic signed [IMU_W-1:0]  gyro_z;
	logic signed [IMU_W-1:0]  accel_x;
	logic signed [IMU_W-1:0]  accel_y;
	logic [TIME_W-1:0]        now_ms;

	modport source (output valid, distance, gyro_z, accel_x, accel_y, now_ms, input ready);
	modport sink   (input valid, distance, gyro_z, accel_x, accel_y, now_ms, output ready);
endinterface

// ----- rtl/core/oanc_result_if.sv -----
// result channel: valid, ready and the command payload
`timescale 1ns / 1ps

interface oanc_result_if
	import oanc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [SPEED_W-1:0]  left_speed;
	logic [SPEED_W-1:0]  right_speed;
	logic [NAV_W-1:0]    nav_mode;

	modport source (output valid, action, left_speed, right_speed, nav_mode, input ready);
	modport sink   (input valid, action, left_speed, right_speed, nav_mode, output ready);
endinterface

// ----- rtl/core/oanc_filter.sv -----
// exponential smoothing of gyro and accel with tilt and rotation flags
`timescale 1ns / 1ps

module oanc_filter
	import oanc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    upd,
	input  logic signed [IMU_W-1:0] gyro_z,
	input  logic signed [IMU_W-1:0] accel_x,
	input  logic signed [IMU_W-1:0] accel_y,
	input  logic [TILT_W-1:0]       tilt_cfg,
	input  logic [ROT_W-1:0]        rot_cfg,
	output imu_flags_t              flags
);
	// smoothed value width and product width
	localparam int SW = FRAC_BITS + 17;
	localparam int PW = SW + 9;

	logic signed [SW-1:0] gyro_q, ax_q, ay_q;
	logic signed [SW-1:0] gyro_n, ax_n, ay_n;
	logic [SW:0]          gyro_mag, ax_mag, ay_mag;
	logic [SW:0]          tilt_fx, rot_fx, dead_fx;

	// s' = floor((s*keep + (x << FRAC_BITS)*take) / 256)
	function automatic logic signed [SW-1:0] smooth(input logic signed [SW-1:0] s,
			input logic signed [IMU_W-1:0] raw, input logic signed [8:0] keep,
			input logic signed [8:0] take);
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] acc;
		x   = PW'(raw) <<< FRAC_BITS;
		acc = PW'(s) * PW'(keep) + x * PW'(take);
		smooth = SW'(acc >>> COEF_SHIFT);
	endfunction

	function automatic logic [SW:0] magn(input logic signed [SW-1:0] v);
		logic signed [SW:0] e;
		e = (SW+1)'(v);
		magn = e[SW] ? (SW+1)'(-e) : (SW+1)'(e);
	endfunction

	// next smoothed values for the sample in flight
	always_comb begin
		gyro_n = smooth(gyro_q, gyro_z, GYRO_KEEP, GYRO_TAKE);
		ax_n   = smooth(ax_q, accel_x, ACC_KEEP, ACC_TAKE);
		ay_n   = smooth(ay_q, accel_y, ACC_KEEP, ACC_TAKE);
	end

	// thresholds in fixed point
	assign tilt_fx = (SW+1)'(tilt_cfg) << FRAC_BITS;
	assign rot_fx  = (SW+1)'(rot_cfg) << FRAC_BITS;
	assign dead_fx = (SW+1)'(DEADZONE) << FRAC_BITS;

	assign gyro_mag = magn(gyro_n);
	assign ax_mag   = magn(ax_n);
	assign ay_mag   = magn(ay_n);

	// status flags
	always_comb begin
		flags.tilt     = (ax_mag > tilt_fx) || (ay_mag > tilt_fx);
		flags.rot_big  = gyro_mag > rot_fx;
		flags.dead_big = gyro_mag > dead_fx;
		flags.gyro_pos = !gyro_n[SW-1] && (gyro_n != '0);
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_q <= '0;
			ax_q   <= '0;
			ay_q   <= '0;
		end else if (upd) begin
			gyro_q <= gyro_n;
			ax_q   <= ax_n;
			ay_q   <= ay_n;
		end
	end

endmodule

// ----- rtl/core/oanc_ctrl.sv -----
// navigation mode machine, timers and servo ramps
`timescale 1ns / 1ps

module oanc_ctrl
	import oanc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    upd,
	input  imu_flags_t              flags,
	input  logic [DIST_W-1:0]       distance,
	input  logic signed [IMU_W-1:0] gyro_z,
	input  logic [TIME_W-1:0]       now_ms,
	input  logic [ROT_W-1:0]        rot_cfg,
	input  logic [DIST_W-1:0]       near_cfg,
	output nav_res_t                res
);
	mode_t               mode_q, mode_n;
	logic [TIME_W-1:0]   mct_q, mct_n;
	logic [TIME_W-1:0]   ct_q, ct_n;
	logic                tln_q, tln_n;
	logic [SPEED_W-1:0]  left_q, left_n;
	logic [SPEED_W-1:0]  right_q, right_n;
	action_t             action;
	logic [TIME_W-1:0]   since_mode, since_corr;
	logic signed [IMU_W:0] gz_ext;
	logic [IMU_W:0]      gz_mag;
	logic                gz_small, gz_big, gz_pos;

	// raw gyro magnitude checks
	assign gz_ext   = (IMU_W+1)'(gyro_z);
	assign gz_mag   = gz_ext[IMU_W] ? (IMU_W+1)'(-gz_ext) : (IMU_W+1)'(gz_ext);
	assign gz_small = gz_mag < (IMU_W+1)'(rot_cfg);
	assign gz_big   = gz_mag > ((IMU_W+1)'(rot_cfg) << 1);
	assign gz_pos   = !gyro_z[IMU_W-1] && (gyro_z != '0);

	assign since_mode = now_ms - mct_q;
	assign since_corr = now_ms - ct_q;

	// next state and command
	always_comb begin
		mode_n  = mode_q;
		mct_n   = mct_q;
		ct_n    = ct_q;
		tln_n   = tln_q;
		left_n  = left_q;
		right_n = right_q;
		action  = ACT_NONE;
		if (flags.tilt) begin
			action = ACT_TILT;
		end else begin
			case (mode_q)
				MODE_AVOID: begin
					if (since_mode < STOP_MS) begin
						action = ACT_STOP;
					end else if (since_mode < TURN_MS) begin
						action = tln_q ? ACT_LEFT : ACT_RIGHT;
					end else begin
						tln_n  = !tln_q;
						mode_n = MODE_FWD;
						mct_n  = now_ms;
					end
				end
				MODE_ADJ: begin
					if (gz_small) begin
						mode_n = MODE_FWD;
						mct_n  = now_ms;
					end else if (gz_pos) begin
						action = ACT_LEFT;
					end else begin
						action = ACT_RIGHT;
					end
				end
				MODE_FWD: begin
					if (flags.rot_big && (since_corr > CORR_MS)) begin
						// correction only outside the deadzone
						if (flags.dead_big) begin
							if (flags.gyro_pos) begin
								left_n  = ramp(left_q, CORR_POS_L, STEP_FAST);
								right_n = ramp(right_q, CORR_POS_R, STEP_FAST);
							end else begin
								left_n  = ramp(left_q, CORR_NEG_L, STEP_FAST);
								right_n = ramp(right_q, CORR_NEG_R, STEP_FAST);
							end
							action = ACT_SERVO;
							ct_n   = now_ms;
						end
					end else begin
						left_n  = ramp(left_q, FWD_L, STEP_SLOW);
						right_n = ramp(right_q, FWD_R, STEP_SLOW);
						action  = ACT_SERVO;
					end
					if (distance < near_cfg) begin
						mode_n = MODE_AVOID;
						mct_n  = now_ms;
						action = ACT_STOP;
					end
				end
				default: begin
					mode_n = MODE_FWD;
				end
			endcase
			// strong raw rotation while heading forward
			if ((mode_n == MODE_FWD) && gz_big) begin
				mode_n = MODE_ADJ;
				mct_n  = now_ms;
			end
		end
	end

	// result fields
	always_comb begin
		res.action      = action;
		res.left_speed  = left_n;
		res.right_speed = right_n;
		case (mode_n)
			MODE_AVOID: res.nav_mode = NAV_AVOID;
			MODE_ADJ:   res.nav_mode = NAV_ADJ;
			default:    res.nav_mode = NAV_FWD;
		endcase
	end

	// navigation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FWD;
			mct_q   <= '0;
			ct_q    <= '0;
			tln_q   <= 1'b0;
			left_q  <= SERVO_RST;
			right_q <= SERVO_RST;
		end else if (upd) begin
			mode_q  <= mode_n;
			mct_q   <= mct_n;
			ct_q    <= ct_n;
			tln_q   <= tln_n;
			left_q  <= left_n;
			right_q <= right_n;
		end
	end

endmodule

// ----- rtl/core/obstacle_avoid_nav_controller_core.sv -----
// Navigation controller: input register, one pass of update logic, result register.
// A sample accepted into the input register moves on to the result register once that is free or being drained.
// Throughput: one sample per cycle while the output is not stalled; the mode and filter state update once per sample.
// A stalled result register holds the input stage, which still takes one more beat if it is empty.
// Reset (arst_n low, asynchronous) empties both stages, restores default thresholds,
// clears the filters, selects forward mode and centers both servos at 90.
`timescale 1ns / 1ps

module obstacle_avoid_nav_controller_core
	import oanc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	oanc_sample_if.sink          in_ch,
	oanc_result_if.source        out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);
	logic                     valid_s1, valid_s2, adv_s1;
	logic [DIST_W-1:0]        distance_s1;
	logic signed [IMU_W-1:0]  gyro_z_s1, accel_x_s1, accel_y_s1;
	logic [TIME_W-1:0]        now_ms_s1;
	nav_res_t                 res_c, res_s2;
	imu_flags_t               flags;
	logic [TILT_W-1:0]        tilt_q;
	logic [ROT_W-1:0]         rot_q;
	logic [DIST_W-1:0]        mindist_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q    <= TILT_RST;
			rot_q     <= ROT_RST;
			mindist_q <= MINDIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TILT:    tilt_q    <= cfg_wdata[TILT_W-1:0];
				CFG_ROT:     rot_q     <= cfg_wdata[ROT_W-1:0];
				CFG_MINDIST: mindist_q <= cfg_wdata[DIST_W-1:0];
				default:     ;
			endcase
		end
	end

	// handshake
	assign adv_s1      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			distance_s1 <= in_ch.distance;
			gyro_z_s1   <= in_ch.gyro_z;
			accel_x_s1  <= in_ch.accel_x;
			accel_y_s1  <= in_ch.accel_y;
			now_ms_s1   <= in_ch.now_ms;
		end
	end

	// smoothing and tilt detection
	oanc_filter #(
		.FRAC_BITS (FRAC_BITS)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (adv_s1),
		.gyro_z   (gyro_z_s1),
		.accel_x  (accel_x_s1),
		.accel_y  (accel_y_s1),
		.tilt_cfg (tilt_q),
		.rot_cfg  (rot_q),
		.flags    (flags)
	);

	// mode machine and servo ramps
	oanc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (adv_s1),
		.flags    (flags),
		.distance (distance_s1),
		.gyro_z   (gyro_z_s1),
		.now_ms   (now_ms_s1),
		.rot_cfg  (rot_q),
		.near_cfg (mindist_q),
		.res      (res_c)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.action      = res_s2.action;
	assign out_ch.left_speed  = res_s2.left_speed;
	assign out_ch.right_speed = res_s2.right_speed;
	assign out_ch.nav_mode    = res_s2.nav_mode;

endmodule

// ----- rtl/core/oanc_checker.sv -----
// port-level checks for the navigation controller, bound to the top level
`timescale 1ns / 1ps

module oanc_checker
	import oanc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ACT_W-1:0]   action,
	input logic [SPEED_W-1:0] left_speed,
	input logic [SPEED_W-1:0] right_speed,
	input logic [NAV_W-1:0]   nav_mode
);
	// a result beat stays offered until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// an unstalled output never blocks the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !out_ready) |-> in_ready)
		else $error("input blocked with free output stage");

	// result codes and servo values stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action <= ACT_TILT) && (left_speed <= 8'd180) &&
			(right_speed <= 8'd180) && (nav_mode <= NAV_ADJ))
		else $error("result field out of range");

	// stop and turn commands only come with avoid or adjust modes
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_STOP || action == ACT_LEFT || action == ACT_RIGHT)
			|-> nav_mode != NAV_FWD)
		else $error("motion command with forward mode");

	// a servo write never leaves the block avoiding
	a_servo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_SERVO |-> nav_mode != NAV_AVOID)
		else $error("servo write while avoiding");

endmodule

bind obstacle_avoid_nav_controller_core oanc_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.action      (out_ch.action),
	.left_speed  (out_ch.left_speed),
	.right_speed (out_ch.right_speed),
	.nav_mode    (out_ch.nav_mode)
);
